[src/source_text_tokenizer_macros.svh]
// Assertion macros used by the tokenizer top level.
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge out of reset.
`define STT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");

// Next-cycle implication.
`define STT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");

`else

`define STT_ASSERT_IMP(lbl, ante, cons)
`define STT_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

[src/stt_pkg.sv]
// Shared types and character constants for the source text tokenizer.
package stt_pkg;

  // Token kinds as seen on the result port
  typedef enum logic [2:0] {
    KIND_EQUAL     = 3'd0,
    KIND_PLUS      = 3'd1,
    KIND_MINUS     = 3'd2,
    KIND_COLON     = 3'd3,
    KIND_SEMICOLON = 3'd4,
    KIND_INTEGER   = 3'd5,
    KIND_IDENT     = 3'd6,
    KIND_ERROR     = 3'd7
  } kind_e;

  // Scanner modes, one-hot
  typedef enum logic [7:0] {
    MODE_IDLE       = 8'b0000_0001,
    MODE_SLASH      = 8'b0000_0010,
    MODE_LINE_CMT   = 8'b0000_0100,
    MODE_BLOCK_CMT  = 8'b0000_1000,
    MODE_BLOCK_STAR = 8'b0001_0000,
    MODE_INTEGER    = 8'b0010_0000,
    MODE_IDENT      = 8'b0100_0000,
    MODE_HALTED     = 8'b1000_0000
  } mode_e;

  // Characters the scanner looks for
  localparam logic [7:0] CHAR_EQUAL     = 8'h3D;
  localparam logic [7:0] CHAR_PLUS      = 8'h2B;
  localparam logic [7:0] CHAR_MINUS     = 8'h2D;
  localparam logic [7:0] CHAR_COLON     = 8'h3A;
  localparam logic [7:0] CHAR_SEMICOLON = 8'h3B;
  localparam logic [7:0] CHAR_SLASH     = 8'h2F;
  localparam logic [7:0] CHAR_STAR      = 8'h2A;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_LF        = 8'h0A;
  localparam logic [7:0] CHAR_FF        = 8'h0C;
  localparam logic [7:0] CHAR_VT        = 8'h0B;
  localparam logic [7:0] CHAR_DIGIT_LO  = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_HI  = 8'h39;
  localparam logic [7:0] CHAR_UPPER_LO  = 8'h41;
  localparam logic [7:0] CHAR_UPPER_HI  = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_LO  = 8'h61;
  localparam logic [7:0] CHAR_LOWER_HI  = 8'h7A;

  // One result as delivered on the port
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] begin_off;
    logic [31:0] end_off;
    logic [23:0] line;
    logic [15:0] column;
    logic [7:0]  bad;
  } result_t;

  // Queue entry: the results caused by one input beat
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } entry_t;

endpackage

[src/source_text_tokenizer.sv]
// Top level of the streaming source text tokenizer.
//
//  channel   direction  handshake        beat
//  --------  ---------  ---------------  -------------------------------------
//  input     in         push_i / full_o  text_byte_i, end_marker_i
//  result    out        pop_i / empty_o  token_kind_o .. bad_byte_o, last_of_run_o
//
// One byte is taken per cycle while the entry queue has room; the scanner
// decides all results of a byte in that cycle. The output stage sends one
// result per cycle while pop_i takes them, so a byte with two results gives
// two beats. Each result passes the entry queue and the output register before
// it reaches the ports. Reset is asynchronous and needs no clearing pass. A
// stalled result side fills the QUEUE_DEPTH-entry queue before full_o rises.
`include "source_text_tokenizer_macros.svh"

module source_text_tokenizer #(
  parameter int OFFSET_BITS = 32,
  parameter int LINE_BITS   = 24,
  parameter int COLUMN_BITS = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_marker_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [2:0]  token_kind_o,
  output logic [31:0] begin_offset_o,
  output logic [31:0] end_offset_o,
  output logic [23:0] line_number_o,
  output logic [15:0] column_number_o,
  output logic [7:0]  bad_byte_o,
  output logic        last_of_run_o
);
  import stt_pkg::*;

  logic    beat, q_push, q_pop, q_full, q_empty;
  entry_t  q_in, q_head;
  result_t res;

  assign beat   = push_i && !q_full;
  assign full_o = q_full;

  // Scanner
  stt_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (beat),
    .text_byte_i  (text_byte_i),
    .end_marker_i (end_marker_i),
    .q_push_o     (q_push),
    .q_entry_o    (q_in)
  );

  // Entry queue
  stt_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .pop_i   (q_pop),
    .data_o  (q_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Output stage
  stt_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (q_head),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .pop_i     (pop_i),
    .empty_o   (empty_o),
    .res_o     (res),
    .last_o    (last_of_run_o)
  );

  assign token_kind_o    = res.kind;
  assign begin_offset_o  = res.begin_off;
  assign end_offset_o    = res.end_off;
  assign line_number_o   = res.line;
  assign column_number_o = res.column;
  assign bad_byte_o      = res.bad;

  // Queue never written when full nor read when empty
  `STT_ASSERT_IMP(a_no_overflow, q_push, !q_full)
  `STT_ASSERT_IMP(a_no_underflow, q_pop, !q_empty)
  // An error is always the last result of its byte
  `STT_ASSERT_IMP(a_error_last, !empty_o && (token_kind_o == KIND_ERROR), last_of_run_o)
  // A pushed entry makes the queue non-empty next cycle
  `STT_ASSERT_NXT(a_push_lands, q_push, !q_empty)

endmodule

[src/stt_front.sv]
// Scanner front end: classifies each byte, tracks position, queues its results.
module stt_front #(
  parameter int OFFSET_BITS = 32,
  parameter int LINE_BITS   = 24,
  parameter int COLUMN_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            beat_i,
  input  logic [7:0]      text_byte_i,
  input  logic            end_marker_i,
  output logic            q_push_o,
  output stt_pkg::entry_t q_entry_o
);
  import stt_pkg::*;

  mode_e                  mode_q, mode_d;
  logic [OFFSET_BITS-1:0] cur_off_q, cur_off_d, tok_off_q, tok_off_d, slash_q, slash_d;
  logic [LINE_BITS-1:0]   cur_line_q, cur_line_d, tok_line_q, tok_line_d;
  logic [COLUMN_BITS-1:0] cur_col_q, cur_col_d, tok_col_q, tok_col_d;

  // Fit internal counters to the fixed result widths
  function automatic logic [31:0] off_out(logic [OFFSET_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

  function automatic logic [23:0] line_out(logic [LINE_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[23:0];
  endfunction

  function automatic logic [15:0] col_out(logic [COLUMN_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[15:0];
  endfunction

  function automatic logic [OFFSET_BITS-1:0] bump_off(logic [OFFSET_BITS-1:0] v);
    return (&v) ? v : v + OFFSET_BITS'(1);
  endfunction

  // Byte classes
  logic [7:0] b;
  logic       is_digit, is_alpha, starts_id, cont_id, is_space, is_lf;
  logic       op_hit;
  kind_e      op_kind;

  assign b         = text_byte_i;
  assign is_digit  = (b >= CHAR_DIGIT_LO) && (b <= CHAR_DIGIT_HI);
  assign is_alpha  = ((b >= CHAR_UPPER_LO) && (b <= CHAR_UPPER_HI)) ||
                     ((b >= CHAR_LOWER_LO) && (b <= CHAR_LOWER_HI));
  assign starts_id = is_alpha || (b == CHAR_UNDERSCORE);
  assign cont_id   = starts_id || is_digit;
  assign is_lf     = (b == CHAR_LF);
  assign is_space  = (b == CHAR_SPACE) || (b == CHAR_CR) || is_lf ||
                     (b == CHAR_FF) || (b == CHAR_VT);

  // Single-character operators
  always_comb begin
    op_hit  = 1'b1;
    op_kind = KIND_EQUAL;
    unique case (b)
      CHAR_EQUAL:     op_kind = KIND_EQUAL;
      CHAR_PLUS:      op_kind = KIND_PLUS;
      CHAR_MINUS:     op_kind = KIND_MINUS;
      CHAR_COLON:     op_kind = KIND_COLON;
      CHAR_SEMICOLON: op_kind = KIND_SEMICOLON;
      default:        op_hit  = 1'b0;
    endcase
  end

  // Outcome of a byte seen between tokens
  logic    idle_hit, idle_slash, idle_tok;
  mode_e   idle_next;
  result_t idle_res;

  always_comb begin
    idle_hit   = 1'b0;
    idle_slash = 1'b0;
    idle_tok   = 1'b0;
    idle_next  = MODE_IDLE;
    idle_res.kind      = KIND_ERROR;
    idle_res.begin_off = off_out(cur_off_q);
    idle_res.end_off   = off_out(bump_off(cur_off_q));
    idle_res.line      = line_out(cur_line_q);
    idle_res.column    = col_out(cur_col_q);
    idle_res.bad       = 8'h00;
    if (is_space) begin
      idle_next = MODE_IDLE;
    end else if (b == CHAR_SLASH) begin
      idle_slash = 1'b1;
      idle_next  = MODE_SLASH;
    end else if (op_hit) begin
      idle_hit      = 1'b1;
      idle_res.kind = op_kind;
    end else if (is_digit) begin
      idle_tok  = 1'b1;
      idle_next = MODE_INTEGER;
    end else if (starts_id) begin
      idle_tok  = 1'b1;
      idle_next = MODE_IDENT;
    end else begin
      idle_hit     = 1'b1;
      idle_res.bad = b;
      idle_next    = MODE_HALTED;
    end
  end

  // Finished run and lone-slash results
  result_t run_res, slash_res;

  always_comb begin
    run_res.kind      = (mode_q == MODE_INTEGER) ? KIND_INTEGER : KIND_IDENT;
    run_res.begin_off = off_out(tok_off_q);
    run_res.end_off   = off_out(cur_off_q);
    run_res.line      = line_out(tok_line_q);
    run_res.column    = col_out(tok_col_q);
    run_res.bad       = 8'h00;
    slash_res.kind      = KIND_ERROR;
    slash_res.begin_off = off_out(slash_q);
    slash_res.end_off   = off_out(bump_off(slash_q));
    slash_res.line      = line_out(tok_line_q);
    slash_res.column    = col_out(tok_col_q);
    slash_res.bad       = CHAR_SLASH;
  end

  // Next state and results for this beat
  logic any_res, apply_idle, do_adv;

  always_comb begin
    mode_d     = mode_q;
    cur_off_d  = cur_off_q;
    tok_off_d  = tok_off_q;
    slash_d    = slash_q;
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    tok_line_d = tok_line_q;
    tok_col_d  = tok_col_q;
    any_res    = 1'b0;
    apply_idle = 1'b0;
    do_adv     = 1'b0;
    q_entry_o.two    = 1'b0;
    q_entry_o.first  = idle_res;
    q_entry_o.second = idle_res;

    if (mode_q == MODE_HALTED) begin
      mode_d = MODE_HALTED;
    end else if (end_marker_i) begin
      // Flush a pending run or slash, then halt
      mode_d = MODE_HALTED;
      if ((mode_q == MODE_INTEGER) || (mode_q == MODE_IDENT)) begin
        any_res         = 1'b1;
        q_entry_o.first = run_res;
      end else if (mode_q == MODE_SLASH) begin
        any_res         = 1'b1;
        q_entry_o.first = slash_res;
      end
    end else begin
      do_adv = 1'b1;
      unique case (mode_q)
        MODE_INTEGER, MODE_IDENT: begin
          if (!(((mode_q == MODE_INTEGER) && is_digit) ||
                ((mode_q == MODE_IDENT) && cont_id))) begin
            any_res          = 1'b1;
            apply_idle       = 1'b1;
            q_entry_o.first  = run_res;
            q_entry_o.two    = idle_hit;
          end
        end
        MODE_SLASH: begin
          if (b == CHAR_SLASH) begin
            mode_d = MODE_LINE_CMT;
          end else if (b == CHAR_STAR) begin
            mode_d = MODE_BLOCK_CMT;
          end else begin
            any_res         = 1'b1;
            q_entry_o.first = slash_res;
            mode_d          = MODE_HALTED;
          end
        end
        MODE_LINE_CMT: begin
          if (is_lf) mode_d = MODE_IDLE;
        end
        MODE_BLOCK_CMT: begin
          if (b == CHAR_STAR) mode_d = MODE_BLOCK_STAR;
        end
        MODE_BLOCK_STAR: begin
          if (b == CHAR_SLASH) begin
            mode_d = MODE_IDLE;
          end else if (b != CHAR_STAR) begin
            mode_d = MODE_BLOCK_CMT;
          end
        end
        MODE_IDLE: begin
          apply_idle = 1'b1;
          any_res    = idle_hit;
        end
        default: begin
          mode_d = MODE_HALTED;
          do_adv = 1'b0;
        end
      endcase
    end

    // Take the between-token outcome
    if (apply_idle) begin
      mode_d = idle_next;
      if (idle_slash) begin
        slash_d    = cur_off_q;
        tok_line_d = cur_line_q;
        tok_col_d  = cur_col_q;
      end
      if (idle_tok) begin
        tok_off_d  = cur_off_q;
        tok_line_d = cur_line_q;
        tok_col_d  = cur_col_q;
      end
    end

    // Advance position unless the byte halted the scanner
    if (do_adv && (mode_d != MODE_HALTED)) begin
      cur_off_d = bump_off(cur_off_q);
      if (is_lf) begin
        cur_line_d = (&cur_line_q) ? cur_line_q : cur_line_q + LINE_BITS'(1);
        cur_col_d  = COLUMN_BITS'(1);
      end else begin
        cur_col_d = (&cur_col_q) ? cur_col_q : cur_col_q + COLUMN_BITS'(1);
      end
    end
  end

  assign q_push_o = beat_i && any_res;

  // Hold state between beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      cur_off_q  <= '0;
      tok_off_q  <= '0;
      slash_q    <= '0;
      cur_line_q <= LINE_BITS'(1);
      cur_col_q  <= COLUMN_BITS'(1);
      tok_line_q <= LINE_BITS'(1);
      tok_col_q  <= COLUMN_BITS'(1);
    end else if (beat_i) begin
      mode_q     <= mode_d;
      cur_off_q  <= cur_off_d;
      tok_off_q  <= tok_off_d;
      slash_q    <= slash_d;
      cur_line_q <= cur_line_d;
      cur_col_q  <= cur_col_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
    end
  end

endmodule

[src/stt_fifo.sv]
// Short queue of per-beat result entries between scanner and output stage.
module stt_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  stt_pkg::entry_t data_i,
  input  logic            pop_i,
  output stt_pkg::entry_t data_o,
  output logic            full_o,
  output logic            empty_o
);
  import stt_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  entry_t          mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
      if (do_pop)  rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

[src/stt_back.sv]
// Output stage: splits queued entries into single results and holds each beat.
module stt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stt_pkg::entry_t  head_i,
  input  logic             q_empty_i,
  output logic             q_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output stt_pkg::result_t res_o,
  output logic             last_o
);
  import stt_pkg::*;

  logic    out_valid_q, sel_q, last_q;
  result_t res_q;
  logic    load, cur_last;
  result_t cur_res;

  assign cur_res  = sel_q ? head_i.second : head_i.first;
  assign cur_last = sel_q || !head_i.two;
  assign load     = !q_empty_i && (!out_valid_q || pop_i);
  assign q_pop_o  = load && cur_last;

  // Track valid and which half of the entry goes next
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      sel_q       <= !cur_last;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the output beat
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= cur_res;
      last_q <= cur_last;
    end
  end

  assign empty_o = !out_valid_q;
  assign res_o   = res_q;
  assign last_o  = last_q;

endmodule

[verif/tb_source_text_tokenizer.sv]
// Self-checking testbench for the source text tokenizer: random text, queue handshakes.
`timescale 1ns / 1ps

module tb_source_text_tokenizer;
  import stt_pkg::*;

  localparam int TEXT_BEATS   = 1300;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 1000000;

  logic        clk_i;
  logic        rst_ni;
  logic        push_i;
  logic        full_o;
  logic [7:0]  text_byte_i;
  logic        end_marker_i;
  logic        empty_o;
  logic        pop_i;
  logic [2:0]  token_kind_o;
  logic [31:0] begin_offset_o;
  logic [31:0] end_offset_o;
  logic [23:0] line_number_o;
  logic [15:0] column_number_o;
  logic [7:0]  bad_byte_o;
  logic        last_of_run_o;

  int gap_max      = 6;
  int burst_left   = 0;
  int beats_sent   = 0;
  bit hold_off_req = 1'b0;

  source_text_tokenizer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push_i),
    .full_o         (full_o),
    .text_byte_i    (text_byte_i),
    .end_marker_i   (end_marker_i),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .token_kind_o   (token_kind_o),
    .begin_offset_o (begin_offset_o),
    .end_offset_o   (end_offset_o),
    .line_number_o  (line_number_o),
    .column_number_o(column_number_o),
    .bad_byte_o     (bad_byte_o),
    .last_of_run_o  (last_of_run_o)
  );

  // Character classes
  function automatic bit is_digit(logic [7:0] b);
    return b >= CHAR_DIGIT_LO && b <= CHAR_DIGIT_HI;
  endfunction

  function automatic bit starts_word(logic [7:0] b);
    return b == CHAR_UNDERSCORE || (b >= CHAR_UPPER_LO && b <= CHAR_UPPER_HI) ||
           (b >= CHAR_LOWER_LO && b <= CHAR_LOWER_HI);
  endfunction

  function automatic bit is_blank(logic [7:0] b);
    return b == CHAR_SPACE || b == CHAR_CR || b == CHAR_LF || b == CHAR_FF ||
           b == CHAR_VT;
  endfunction

  // Saturating step of a byte offset
  function automatic logic [31:0] next_offset(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  typedef struct packed {
    result_t res;
    logic    last;
  } expected_t;

  // Tracks the scanner state and holds the tokens still owed by the block
  class token_scoreboard;
    mode_e       mode;
    logic [31:0] cur_off;
    logic [31:0] run_off;
    logic [31:0] slash_off;
    logic [23:0] cur_line;
    logic [23:0] mark_line;
    logic [15:0] cur_col;
    logic [15:0] mark_col;
    expected_t   expected_tokens[$];
    int          mismatches;

    function new();
      mode       = MODE_IDLE;
      cur_off    = '0;
      run_off    = '0;
      slash_off  = '0;
      cur_line   = 24'd1;
      mark_line  = 24'd1;
      cur_col    = 16'd1;
      mark_col   = 16'd1;
      mismatches = 0;
    endfunction

    function void add(kind_e kind, logic [31:0] b, logic [31:0] e, logic [23:0] l,
                      logic [15:0] c, logic [7:0] bad);
      expected_t t;
      t.res.kind      = kind;
      t.res.begin_off = b;
      t.res.end_off   = e;
      t.res.line      = l;
      t.res.column    = c;
      t.res.bad       = bad;
      t.last          = 1'b0;
      expected_tokens.push_back(t);
    endfunction

    function void add_run();
      if (mode == MODE_INTEGER)
        add(KIND_INTEGER, run_off, cur_off, mark_line, mark_col, 8'h00);
      else
        add(KIND_IDENT, run_off, cur_off, mark_line, mark_col, 8'h00);
    endfunction

    function void add_slash_error();
      add(KIND_ERROR, slash_off, next_offset(slash_off), mark_line, mark_col, CHAR_SLASH);
      mode = MODE_HALTED;
    endfunction

    // Byte seen while no token is open
    function void between_tokens(logic [7:0] b);
      logic [31:0] nx;
      nx = next_offset(cur_off);
      if (is_blank(b)) return;
      case (b)
        CHAR_SLASH: begin
          slash_off = cur_off;
          mark_line = cur_line;
          mark_col  = cur_col;
          mode      = MODE_SLASH;
        end
        CHAR_EQUAL:     add(KIND_EQUAL, cur_off, nx, cur_line, cur_col, 8'h00);
        CHAR_PLUS:      add(KIND_PLUS, cur_off, nx, cur_line, cur_col, 8'h00);
        CHAR_MINUS:     add(KIND_MINUS, cur_off, nx, cur_line, cur_col, 8'h00);
        CHAR_COLON:     add(KIND_COLON, cur_off, nx, cur_line, cur_col, 8'h00);
        CHAR_SEMICOLON: add(KIND_SEMICOLON, cur_off, nx, cur_line, cur_col, 8'h00);
        default: begin
          if (is_digit(b) || starts_word(b)) begin
            run_off   = cur_off;
            mark_line = cur_line;
            mark_col  = cur_col;
            mode      = is_digit(b) ? MODE_INTEGER : MODE_IDENT;
          end else begin
            add(KIND_ERROR, cur_off, nx, cur_line, cur_col, b);
            mode = MODE_HALTED;
          end
        end
      endcase
    endfunction

    // Predict the tokens of one accepted input beat
    function void note_byte(logic [7:0] b, logic at_end);
      int        first;
      expected_t t;
      first = expected_tokens.size();
      if (mode == MODE_HALTED) return;
      if (at_end) begin
        if (mode == MODE_INTEGER || mode == MODE_IDENT) add_run();
        else if (mode == MODE_SLASH) add_slash_error();
        mode = MODE_HALTED;
      end else begin
        case (mode)
          MODE_INTEGER, MODE_IDENT: begin
            if (!(mode == MODE_INTEGER ? is_digit(b) : (is_digit(b) || starts_word(b)))) begin
              add_run();
              mode = MODE_IDLE;
              between_tokens(b);
            end
          end
          MODE_SLASH: begin
            if (b == CHAR_SLASH) mode = MODE_LINE_CMT;
            else if (b == CHAR_STAR) mode = MODE_BLOCK_CMT;
            else add_slash_error();
          end
          MODE_LINE_CMT: begin
            if (b == CHAR_LF) mode = MODE_IDLE;
          end
          MODE_BLOCK_CMT: begin
            if (b == CHAR_STAR) mode = MODE_BLOCK_STAR;
          end
          MODE_BLOCK_STAR: begin
            if (b == CHAR_SLASH) mode = MODE_IDLE;
            else if (b != CHAR_STAR) mode = MODE_BLOCK_CMT;
          end
          default: between_tokens(b);
        endcase
        // Advance position counters, saturating
        if (mode != MODE_HALTED) begin
          cur_off = next_offset(cur_off);
          if (b == CHAR_LF) begin
            if (cur_line != '1) cur_line = cur_line + 24'd1;
            cur_col = 16'd1;
          end else if (cur_col != '1) begin
            cur_col = cur_col + 16'd1;
          end
        end
      end
      // Flag the last token of this beat
      if (expected_tokens.size() > first) begin
        t = expected_tokens.pop_back();
        t.last = 1'b1;
        expected_tokens.push_back(t);
      end
    endfunction

    // Compare one popped token with the oldest one owed
    function void check_token(result_t got, logic got_last);
      expected_t want;
      if (expected_tokens.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected token: kind %0d begin %0d end %0d line %0d col %0d bad %02h",
                   got.kind, got.begin_off, got.end_off, got.line, got.column, got.bad);
        mismatches++;
        return;
      end
      want = expected_tokens.pop_front();
      if (got.kind !== want.res.kind || got.begin_off !== want.res.begin_off ||
          got.end_off !== want.res.end_off || got.line !== want.res.line ||
          got.column !== want.res.column || got.bad !== want.res.bad ||
          got_last !== want.last) begin
        if (mismatches < 10) begin
          $display("token mismatch");
          $display("  expected kind %0d beg %0d end %0d ln %0d col %0d bad %02h last %0b",
                   want.res.kind, want.res.begin_off, want.res.end_off, want.res.line,
                   want.res.column, want.res.bad, want.last);
          $display("  got      kind %0d beg %0d end %0d ln %0d col %0d bad %02h last %0b",
                   got.kind, got.begin_off, got.end_off, got.line, got.column, got.bad,
                   got_last);
        end
        mismatches++;
      end
    endfunction
  endclass

  token_scoreboard board = new();

  // Clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Watch both handshakes at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push_i && !full_o) board.note_byte(text_byte_i, end_marker_i);
      if (pop_i && !empty_o)
        board.check_token(result_t'({token_kind_o, begin_offset_o, end_offset_o,
                                     line_number_o, column_number_o, bad_byte_o}),
                          last_of_run_o);
    end
  end

  // Give up on a hang
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  // Pop on a changing pattern, with one long hold-off on request
  initial begin : result_sink
    int hold_left;
    int mode_left;
    int pattern;
    hold_left = 0;
    mode_left = 0;
    pattern   = 0;
    pop_i     = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (mode_left == 0) begin
        pattern   = $urandom_range(0, 2);
        mode_left = $urandom_range(8, 80);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        pop_i <= 1'b0;
      end else begin
        case (pattern)
          0:       pop_i <= 1'b1;
          1:       pop_i <= 1'($urandom_range(0, 1));
          default: pop_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one beat in bursts with random gaps, hold until taken
  task automatic push_beat(input logic [7:0] b, input logic at_end = 1'b0);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      repeat (gap) begin
        @(negedge clk_i);
        push_i       <= 1'b0;
        text_byte_i  <= 8'($urandom);
        end_marker_i <= 1'($urandom);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    push_i       <= 1'b1;
    text_byte_i  <= b;
    end_marker_i <= at_end;
    do @(posedge clk_i); while (full_o);
    beats_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_beat(s[i]);
  endtask

  function automatic logic [7:0] word_char(input bit first);
    int n;
    n = first ? $urandom_range(0, 52) : $urandom_range(0, 62);
    if (n < 26) return 8'(CHAR_UPPER_LO + n);
    if (n < 52) return 8'(CHAR_LOWER_LO + (n - 26));
    if (n == 52) return CHAR_UNDERSCORE;
    return 8'(CHAR_DIGIT_LO + (n - 53));
  endfunction

  // One well-formed piece of text with random content
  task automatic send_random_piece();
    int          n;
    logic [7:0]  c;
    logic [7:0]  prev;
    n    = $urandom_range(0, 12);
    prev = 8'h00;
    case ($urandom_range(0, 9))
      0, 1: begin
        push_beat(8'(CHAR_DIGIT_LO + $urandom_range(0, 9)));
        repeat (n % 6) push_beat(8'(CHAR_DIGIT_LO + $urandom_range(0, 9)));
      end
      2, 3: begin
        push_beat(word_char(1'b1));
        repeat (n % 8) push_beat(word_char(1'b0));
      end
      4, 5: begin
        case ($urandom_range(0, 4))
          0:       push_beat(CHAR_EQUAL);
          1:       push_beat(CHAR_PLUS);
          2:       push_beat(CHAR_MINUS);
          3:       push_beat(CHAR_COLON);
          default: push_beat(CHAR_SEMICOLON);
        endcase
      end
      6, 7: begin
        repeat (n % 3 + 1) begin
          case ($urandom_range(0, 4))
            0:       push_beat(CHAR_SPACE);
            1:       push_beat(CHAR_CR);
            2:       push_beat(CHAR_LF);
            3:       push_beat(CHAR_FF);
            default: push_beat(CHAR_VT);
          endcase
        end
      end
      8: begin
        push_beat(CHAR_SLASH);
        push_beat(CHAR_SLASH);
        repeat (n) begin
          c = 8'($urandom);
          if (c == CHAR_LF) c = CHAR_SPACE;
          push_beat(c);
        end
        push_beat(CHAR_LF);
      end
      default: begin
        // Block comment: any bytes, but no early star-slash
        push_beat(CHAR_SLASH);
        push_beat(CHAR_STAR);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0:       c = CHAR_STAR;
            1:       c = CHAR_SLASH;
            default: c = 8'($urandom);
          endcase
          if (prev == CHAR_STAR && c == CHAR_SLASH) c = CHAR_STAR;
          push_beat(c);
          prev = c;
        end
        push_beat(CHAR_STAR);
        push_beat(CHAR_SLASH);
      end
    endcase
  endtask

  // Main sequence
  initial begin : text_source
    logic [7:0] c;
    bit         pressure_done;
    pressure_done = 1'b0;
    rst_ni        = 1'b0;
    push_i        = 1'b0;
    text_byte_i   = 8'h00;
    end_marker_i  = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every token, blanks, both comment forms, run ended by a token
    send_text("=+-:;");
    push_beat(CHAR_SPACE);
    send_text("09");
    push_beat(CHAR_CR);
    push_beat(CHAR_LF);
    send_text("AZ_az");
    push_beat(CHAR_FF);
    push_beat(CHAR_VT);
    send_text("//");
    push_beat(8'hFF);
    push_beat(CHAR_LF);
    send_text("/*");
    push_beat(8'h00);
    send_text("**/7q:");

    // Random well-formed text, with one long receiver hold-off
    while (beats_sent < TEXT_BEATS) begin
      if (!pressure_done && beats_sent > 400) begin
        hold_off_req = 1'b1;
        gap_max      = 0;
        repeat (40) push_beat(CHAR_SEMICOLON);
        gap_max       = 6;
        pressure_done = 1'b1;
      end
      send_random_piece();
    end

    // Halt the scanner one way or another
    case ($urandom_range(0, 6))
      0: begin
        do c = 8'($urandom);
        while (is_blank(c) || is_digit(c) || starts_word(c) || c == CHAR_SLASH ||
               c == CHAR_EQUAL || c == CHAR_PLUS || c == CHAR_MINUS ||
               c == CHAR_COLON || c == CHAR_SEMICOLON);
        push_beat(c);
      end
      1: begin
        push_beat(CHAR_SLASH);
        do c = 8'($urandom); while (c == CHAR_SLASH || c == CHAR_STAR);
        push_beat(c);
      end
      2: begin
        push_beat($urandom_range(0, 1) ? word_char(1'b1) : CHAR_DIGIT_LO);
        push_beat(8'($urandom), 1'b1);
      end
      3: begin
        push_beat(CHAR_SLASH);
        push_beat(8'($urandom), 1'b1);
      end
      4: begin
        send_text("/*a");
        push_beat(8'($urandom), 1'b1);
      end
      5: begin
        send_text("//a");
        push_beat(8'($urandom), 1'b1);
      end
      default: begin
        push_beat(CHAR_SPACE);
        push_beat(8'($urandom), 1'b1);
      end
    endcase

    // Beats after the halt must give nothing
    repeat (6) push_beat(8'($urandom), 1'($urandom));
    @(negedge clk_i);
    push_i <= 1'b0;

    // Drain and report
    while (board.expected_tokens.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.expected_tokens.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[source_text_tokenizer.f]
+incdir+src
src/stt_pkg.sv
src/stt_front.sv
src/stt_fifo.sv
src/stt_back.sv
src/source_text_tokenizer.sv
verif/tb_source_text_tokenizer.sv
